// ===== hw/rtl/shp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_pkg
// Shared constants, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int SHP_INDEX_BITS    = 24;
  localparam int SHP_FRACTION_BITS = 24;
  localparam int CFG_DATA_BITS     = 24;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int BASE_BITS         = 5;
  localparam int CORDIC_STEPS      = 30;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_POINT_COUNT  = 2'd0,
    REG_BASE_POLAR   = 2'd1,
    REG_BASE_AZIMUTH = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/shp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface shp_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface shp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  logic signed [15:0] z_coord;
  logic        [23:0] sample_index;
  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  output sample_index, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                  input sample_index, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/shp_radinv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_radinv
// Radical inverse unit: bit-serial digit extraction, then long division.
// ----------------------------------------------------------------------------
module shp_radinv #(
  parameter int IB = 24,
  parameter int FB = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [IB-1:0] k,
  input  wire logic [4:0]    base,
  output logic               done,
  output logic [31:0]        frac
);
  import shp_pkg::*;

  localparam int NW = IB + BASE_BITS;
  localparam int MX = (IB > FB) ? IB : FB;
  localparam int CW = $clog2(MX);

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_UPD, R_FRAC} rstate_t;

  rstate_t         state;
  logic [IB-1:0]   kq;
  logic [4:0]      rr;
  logic [4:0]      b;
  logic [CW-1:0]   cnt;
  logic [NW-1:0]   num;
  logic [NW-1:0]   den;
  logic [FB-1:0]   quo;

  logic [5:0]      dsh;
  logic            dge;
  logic [NW:0]     fsh;
  logic            fge;
  logic [NW-1:0]   num_next;
  logic [NW-1:0]   den_next;

  always_comb begin
    dsh      = {rr, kq[IB-1]};
    dge      = dsh >= {1'b0, b};
    fsh      = {num, 1'b0};
    fge      = fsh >= {1'b0, den};
    num_next = NW'(num * b) + NW'(rr);
    den_next = NW'(den * b);
  end

  assign frac = 32'(quo) << (32 - FB);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (start) begin
            kq    <= k;
            b     <= (base < 5'd2) ? 5'd2 : base;
            rr    <= '0;
            cnt   <= '0;
            num   <= '0;
            den   <= NW'(1);
            state <= R_DIV;
          end
        end
        R_DIV: begin
          // one quotient bit of k / b per cycle
          rr  <= dge ? 5'(dsh - {1'b0, b}) : dsh[4:0];
          kq  <= {kq[IB-2:0], dge};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(IB - 1)) state <= R_UPD;
        end
        R_UPD: begin
          num <= num_next;
          den <= den_next;
          rr  <= '0;
          cnt <= '0;
          if (kq == '0) begin
            quo   <= '0;
            state <= R_FRAC;
          end else begin
            state <= R_DIV;
          end
        end
        R_FRAC: begin
          // num doubles as the division remainder here
          num <= fge ? NW'(fsh - {1'b0, den}) : fsh[NW-1:0];
          quo <= {quo[FB-2:0], fge};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(FB - 1)) begin
            done  <= 1'b1;
            state <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/shp_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_isqrt
// Integer square root of a 61-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module shp_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [60:0] v_in,
  output logic             done,
  output logic [30:0]      root
);
  import shp_pkg::*;

  typedef enum logic {Q_IDLE, Q_RUN} qstate_t;

  qstate_t     state;
  logic [60:0] v;
  logic [60:0] res;
  logic [60:0] bt;
  logic [4:0]  cnt;
  logic [60:0] trial;

  assign trial = res + bt;
  assign root  = res[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        Q_IDLE: begin
          if (start) begin
            v     <= v_in;
            res   <= '0;
            bt    <= 61'(1) << 60;
            cnt   <= '0;
            state <= Q_RUN;
          end
        end
        Q_RUN: begin
          if (v >= trial) begin
            v   <= v - trial;
            res <= (res >> 1) + bt;
          end else begin
            res <= res >> 1;
          end
          bt  <= bt >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == 5'd30) begin
            done  <= 1'b1;
            state <= Q_IDLE;
          end
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/shp_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_cordic
// Iterative CORDIC rotator giving cos and sin in Q.30 of an angle in turns.
// ----------------------------------------------------------------------------
module shp_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [31:0]        angle,
  output logic                    done,
  output logic signed [32:0]      cos_v,
  output logic signed [32:0]      sin_v
);
  import shp_pkg::*;

  typedef enum logic {C_IDLE, C_RUN} cstate_t;

  cstate_t            state;
  logic [1:0]         quad;
  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [32:0] ang;
  logic [4:0]         cnt;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] at;

  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    at = $signed({1'b0, atan_turn(cnt)});
    case (quad)
      2'd0: begin cos_v = x;  sin_v = y;  end
      2'd1: begin cos_v = -y; sin_v = x;  end
      2'd2: begin cos_v = -x; sin_v = -y; end
      default: begin cos_v = y; sin_v = -x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            quad  <= angle[31:30];
            ang   <= $signed({3'b000, angle[29:0]});
            x     <= CORDIC_GAIN;
            y     <= '0;
            cnt   <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (ang >= 0) begin
            x <= x - dx; y <= y + dy; ang <= ang - at;
          end else begin
            x <= x + dx; y <= y - dy; ang <= ang + at;
          end
          cnt <= cnt + 1'b1;
          if (cnt == 5'(CORDIC_STEPS - 1)) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sphere_halton_point.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_halton_point
// Halton point set on the unit sphere, one point per request item.
// ----------------------------------------------------------------------------
// Each request item returns the next point (x, y, z in signed Q1.15, plus the
// index used). The block takes one item at a time: req.ready is high only
// while the sequencer is idle. Each item runs the shared radical inverse
// unit, one quotient bit per cycle, first in the polar radix and then in the
// azimuth radix; square root and CORDIC then run side by side.
// A finished item waits in the output register; a new request may be taken
// while it waits. Registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle, and the block itself
// does not enforce this; a write to point_count restarts the index.
module sphere_halton_point
  import shp_pkg::*;
#(
  parameter int INDEX_BITS    = SHP_INDEX_BITS,
  parameter int FRACTION_BITS = SHP_FRACTION_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  shp_req_if.sink                        req,
  shp_rsp_if.source                      rsp,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CMPW = (INDEX_BITS > 24) ? INDEX_BITS : 24;

  typedef enum logic [3:0] {
    S_IDLE, S_RP, S_MAG, S_RA, S_TRIG, S_MX, S_MY, S_MZ, S_OUT
  } state_t;

  state_t                  state;
  logic [23:0]             point_count;
  logic [4:0]              base_polar;
  logic [4:0]              base_azimuth;
  logic [INDEX_BITS-1:0]   counter;
  logic [INDEX_BITS-1:0]   k;
  logic signed [31:0]      z30;
  logic [60:0]             vsq;
  logic                    sq_ok;
  logic                    co_ok;
  logic [30:0]             rad;
  logic signed [32:0]      cv;
  logic signed [32:0]      sv;
  logic signed [63:0]      prod;
  logic signed [15:0]      xq;
  logic signed [15:0]      yq;
  logic signed [15:0]      zq;
  logic                    out_valid;
  logic signed [15:0]      out_x;
  logic signed [15:0]      out_y;
  logic signed [15:0]      out_z;
  logic [23:0]             out_idx;

  logic                    ri_start;
  logic [INDEX_BITS-1:0]   ri_k;
  logic [4:0]              ri_base;
  logic                    ri_done;
  logic [31:0]             ri_frac;
  logic                    trig_start;
  logic                    sq_done;
  logic [30:0]             sq_root;
  logic                    co_done;
  logic signed [32:0]      co_cos;
  logic signed [32:0]      co_sin;

  logic                    req_fire;
  logic [INDEX_BITS-1:0]   k_new;
  logic [INDEX_BITS-1:0]   k_inc;
  logic [30:0]             mag;
  logic signed [31:0]      z30_new;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] r);
    logic signed [15:0] q;
    if (r > 64'sd32767)       q = 16'sh7FFF;
    else if (r < -64'sd32768) q = 16'sh8000;
    else                      q = r[15:0];
    return q;
  endfunction

  assign req_fire = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    k_new = counter;
    if (req.restart || counter == '0 ||
        CMPW'(counter) >= CMPW'(point_count)) k_new = INDEX_BITS'(1);
    k_inc   = k + 1'b1;
    z30_new = $signed({1'b0, ri_frac[31:2], 1'b0}) - 32'sd1073741824;
    mag     = (z30 < 0) ? 31'(-z30) : 31'(z30);
    // radical inverse unit: polar pass from idle, azimuth pass after
    ri_start = req_fire || (state == S_MAG);
    ri_k     = (state == S_IDLE) ? k_new : k;
    ri_base  = (state == S_IDLE) ? base_polar : base_azimuth;
    trig_start = (state == S_RA) && ri_done;
  end

  shp_radinv #(.IB(INDEX_BITS), .FB(FRACTION_BITS)) u_radinv (
    .clk, .rst, .start(ri_start), .k(ri_k), .base(ri_base),
    .done(ri_done), .frac(ri_frac)
  );

  shp_isqrt u_isqrt (
    .clk, .rst, .start(trig_start), .v_in(vsq), .done(sq_done), .root(sq_root)
  );

  shp_cordic u_cordic (
    .clk, .rst, .start(trig_start), .angle({ri_frac[30:0], 1'b0}),
    .done(co_done), .cos_v(co_cos), .sin_v(co_sin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= 24'd1024;
      base_polar   <= 5'd2;
      base_azimuth <= 5'd3;
      counter      <= INDEX_BITS'(1);
      out_valid    <= 1'b0;
      sq_ok        <= 1'b0;
      co_ok        <= 1'b0;
    end else begin
      // load a finished item when the output register is free, else drop
      // the one just taken
      if (state == S_OUT && (!out_valid || rsp.ready)) out_valid <= 1'b1;
      else if (rsp.valid && rsp.ready)                 out_valid <= 1'b0;
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_POINT_COUNT: begin
            point_count <= cfg_data;
            counter     <= INDEX_BITS'(1);
          end
          REG_BASE_POLAR:   base_polar   <= cfg_data[4:0];
          REG_BASE_AZIMUTH: base_azimuth <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            k     <= k_new;
            state <= S_RP;
          end
        end
        S_RP: begin
          if (ri_done) begin
            z30   <= z30_new;
            state <= S_MAG;
          end
        end
        S_MAG: begin
          // ring radius squared: 1 - z^2 in Q.60
          vsq     <= (61'(1) << 60) - 61'(mag * mag);
          counter <= (k_inc == '0) ? INDEX_BITS'(1) : k_inc;
          state   <= S_RA;
        end
        S_RA: begin
          if (ri_done) begin
            sq_ok <= 1'b0;
            co_ok <= 1'b0;
            state <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (sq_done) begin
            rad   <= sq_root;
            sq_ok <= 1'b1;
          end
          if (co_done) begin
            cv    <= co_cos;
            sv    <= co_sin;
            co_ok <= 1'b1;
          end
          if (sq_ok && co_ok) state <= S_MX;
        end
        S_MX: begin
          prod  <= 64'($signed({1'b0, rad}) * cv);
          state <= S_MY;
        end
        S_MY: begin
          xq    <= sat16((prod + (64'sd1 <<< 44)) >>> 45);
          prod  <= 64'($signed({1'b0, rad}) * sv);
          state <= S_MZ;
        end
        S_MZ: begin
          yq    <= sat16((prod + (64'sd1 <<< 44)) >>> 45);
          zq    <= sat16((64'(z30) + 64'sd16384) >>> 15);
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_x     <= xq;
            out_y     <= yq;
            out_z     <= zq;
            out_idx   <= 24'(k);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.x_coord      = out_x;
  assign rsp.y_coord      = out_y;
  assign rsp.z_coord      = out_z;
  assign rsp.sample_index = out_idx;

endmodule
`default_nettype wire

// ===== hw/rtl/shp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_checker
// Port-level checks for the sphere point generator, bound to the top level.
// ----------------------------------------------------------------------------
module shp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [15:0] rsp_x,
  input wire logic [23:0] rsp_idx
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_idx))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_idx != 24'd0)
    else $error("zero sample index");

endmodule

bind sphere_halton_point shp_checker u_shp_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_x(rsp.x_coord), .rsp_idx(rsp.sample_index)
);
`default_nettype wire

// ===== tb/tb_sphere_halton_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_halton_point
// Self-checking bench for the Halton sphere point generator. Request items
// are fed from a queue under random back-pressure on both channels. Each
// accepted request is run through a bit-exact model held in this bench:
// radical inverses, square root, CORDIC and Q1.15 rounding. Each result item
// is compared with the oldest predicted point. Registers are rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_sphere_halton_point;
  import shp_pkg::*;

  localparam int  CLK_HALF    = 4;
  localparam int  RESET_TICKS = 9;
  localparam longint CYCLE_LIMIT = 64'd8000000;
  localparam int  DRAIN_TICKS = 3000;
  localparam int  LONG_HOLD   = 4000;
  localparam int  MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic        [23:0] idx;
  } point_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam longint ATAN_LUT [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_POINT_COUNT;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  shp_req_if req ();
  shp_rsp_if rsp ();

  sphere_halton_point u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Model copy of the registers and the sample counter.
  logic [23:0] mdl_count;
  logic [4:0]  mdl_base_polar;
  logic [4:0]  mdl_base_azimuth;
  logic [23:0] mdl_counter;

  bit     restart_pending [$];
  point_t points_due [$];

  logic   req_taken = 1'b0;
  int     req_gap = 0;
  int     rsp_gap = 0;
  int     long_left = 0;
  bit     long_done = 1'b0;
  int     points_seen = 0;
  int     mismatches = 0;
  longint cycles = 0;

  initial begin
    req.valid   = 1'b0;
    req.restart = 1'b0;
    rsp.ready   = 1'b0;
  end

  // Radical inverse of k, exact digit reversal then 24 quotient bits, as 0.32.
  function automatic longint unsigned radical_fraction(input logic [23:0] k,
                                                       input logic [4:0] b);
    longint unsigned radix, kk, num, den, rem, quo;
    radix = (b < 2) ? 64'd2 : 64'(b);
    kk = 64'(k);
    num = 0;
    den = 1;
    quo = 0;
    while (kk != 0) begin
      num = num * radix + kk % radix;
      den = den * radix;
      kk  = kk / radix;
    end
    rem = num;
    for (int i = 0; i < 24; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return (quo << 8) & 64'hFFFF_FFFF;
  endfunction

  function automatic longint unsigned ring_radius(input longint unsigned v);
    longint unsigned res, bitv, rest;
    res = 0;
    bitv = 64'd1 << 60;
    rest = v;
    for (int i = 0; i < 31; i++) begin
      if (rest >= res + bitv) begin
        rest = rest - (res + bitv);
        res  = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] round_q15(input longint v, input int sh);
    longint r;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Next point of the set; advances the model counter.
  function automatic point_t next_sphere_point(input bit restart);
    point_t p;
    logic [23:0] k;
    longint unsigned r32, s32, a32, mag, rad;
    longint z30, cx, cy, ang, dx, dy, c, s;
    k = mdl_counter;
    if (restart || k == 0) k = 24'd1;
    if (k >= mdl_count) k = 24'd1;
    r32 = radical_fraction(k, mdl_base_polar);
    z30 = 2 * longint'(r32 >> 2) - (longint'(1) <<< 30);
    mag = (z30 < 0) ? longint'(-z30) : longint'(z30);
    rad = ring_radius((64'd1 << 60) - mag * mag);
    s32 = radical_fraction(k, mdl_base_azimuth);
    a32 = (s32 << 1) & 64'hFFFF_FFFF;
    cx  = CORDIC_GAIN;
    cy  = 0;
    ang = longint'(a32 & 64'h3FFF_FFFF);
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (ang >= 0) begin
        cx = cx - dx; cy = cy + dy; ang = ang - ATAN_LUT[i];
      end else begin
        cx = cx + dx; cy = cy - dy; ang = ang + ATAN_LUT[i];
      end
    end
    case (a32[31:30])
      2'd0: begin c = cx;  s = cy;  end
      2'd1: begin c = -cy; s = cx;  end
      2'd2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
    p.x   = round_q15(longint'(rad) * c, 45);
    p.y   = round_q15(longint'(rad) * s, 45);
    p.z   = round_q15(z30, 15);
    p.idx = k;
    // Wrap to one on overflow of the counter.
    mdl_counter = k + 24'd1;
    if (mdl_counter == 0) mdl_counter = 24'd1;
    return p;
  endfunction

  // Mostly short gaps, with runs of none and the odd long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sphere_halton_point verification failed");
      $finish;
    end
  end

  // Request side: note acceptance and predict the point it produces.
  always @(posedge clk) begin
    req_taken <= req.valid && req.ready;
    if (!rst && req.valid && req.ready)
      points_due.push_back(next_sphere_point(req.restart));
  end

  // Request driver: hold the item until taken, then idle or offer the next.
  always @(negedge clk) begin
    if (!rst) begin
      if (req.valid && !req_taken) begin
        // hold
      end else if (req_gap > 0) begin
        req.valid <= 1'b0;
        req_gap   <= req_gap - 1;
      end else if (restart_pending.size() > 0) begin
        req.valid   <= 1'b1;
        req.restart <= restart_pending.pop_front();
        req_gap     <= pick_gap();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Long hold-off of the receiver once early in the run, so that the output
  // register fills and the block stalls its input.
  always @(negedge clk) begin
    if (points_seen == 30 && !long_done) begin
      long_left <= LONG_HOLD;
      long_done <= 1'b1;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
    end
  end

  // Result ready: random gaps, dropped during the long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_gap > 0) begin
        rsp.ready <= 1'b0;
        rsp_gap   <= rsp_gap - 1;
      end else begin
        rsp.ready <= (long_left == 0);
        rsp_gap   <= pick_gap();
      end
    end
  end

  // Result checker: compare each field with the oldest predicted point.
  always @(posedge clk) begin
    point_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      points_seen <= points_seen + 1;
      if (points_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS)
          $display("unexpected point idx=%0d x=%0d y=%0d z=%0d", rsp.sample_index,
                   rsp.x_coord, rsp.y_coord, rsp.z_coord);
      end else begin
        want = points_due.pop_front();
        if (rsp.x_coord !== want.x || rsp.y_coord !== want.y ||
            rsp.z_coord !== want.z || rsp.sample_index !== want.idx) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("point mismatch: want idx=%0d x=%0d y=%0d z=%0d, got idx=%0d x=%0d y=%0d z=%0d",
                     want.idx, want.x, want.y, want.z, rsp.sample_index,
                     rsp.x_coord, rsp.y_coord, rsp.z_coord);
        end
      end
    end
  end

  // Write one register on the next clock; the caller lowers the enable.
  task automatic write_reg(input reg_index_t idx, input logic [23:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_POINT_COUNT: begin
        mdl_count   = value;
        mdl_counter = 24'd1;
      end
      REG_BASE_POLAR:   mdl_base_polar   = value[4:0];
      REG_BASE_AZIMUTH: mdl_base_azimuth = value[4:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Wait until no request is pending and every point has come back.
  task automatic wait_idle();
    while (restart_pending.size() > 0 || req.valid || points_due.size() > 0)
      @(negedge clk);
  endtask

  // Reprogram all three registers, bases first so the count write restarts.
  task automatic program_set(input logic [23:0] count, input logic [4:0] bp,
                             input logic [4:0] ba);
    wait_idle();
    write_reg(REG_BASE_POLAR,   {19'($urandom_range(0, 524287)), bp});
    write_reg(REG_BASE_AZIMUTH, {19'($urandom_range(0, 524287)), ba});
    write_reg(REG_POINT_COUNT,  count);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_requests(input int n, input int restart_pct);
    for (int i = 0; i < n; i++)
      restart_pending.push_back($urandom_range(0, 99) < restart_pct);
  endtask

  initial begin
    int n_items;
    mdl_count        = 24'd1024;
    mdl_base_polar   = 5'd2;
    mdl_base_azimuth = 5'd3;
    mdl_counter      = 24'd1;
    repeat (RESET_TICKS) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings with restart both ways.
    restart_pending.push_back(1'b1);
    restart_pending.push_back(1'b0);
    restart_pending.push_back(1'b0);
    restart_pending.push_back(1'b0);
    restart_pending.push_back(1'b1);
    restart_pending.push_back(1'b0);

    // Unknown register index: no effect.
    wait_idle();
    write_reg(REG_UNUSED, 24'hFFFFFF);
    cfg_write <= 1'b0;
    restart_pending.push_back(1'b0);
    restart_pending.push_back(1'b0);

    // Small point counts: every point uses index one.
    program_set(24'd2, 5'd2, 5'd3);
    queue_requests(3, 0);
    program_set(24'd0, 5'd2, 5'd3);
    queue_requests(2, 0);
    program_set(24'd1, 5'd2, 5'd3);
    queue_requests(2, 0);

    // Radix below two falls back to two; widest radix; largest count.
    program_set(24'd20, 5'd0, 5'd1);
    queue_requests(3, 0);
    program_set(24'hFFFFFF, 5'd31, 5'd31);
    queue_requests(4, 0);

    // Random phases: mostly small counts, occasionally the extremes.
    n_items = 0;
    while (n_items < 1650) begin
      int r;
      int n;
      logic [23:0] cnt;
      r = $urandom_range(0, 9);
      if (r == 0)      cnt = 24'hFFFFFF;
      else if (r == 1) cnt = 24'($urandom_range(0, 2));
      else             cnt = 24'($urandom_range(3, 300));
      program_set(cnt, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      n = $urandom_range(60, 160);
      queue_requests(n, $urandom_range(0, 1) ? 3 : 15);
      n_items = n_items + n;
    end

    // Drain, then allow for a block still at work.
    wait_idle();
    repeat (DRAIN_TICKS) @(posedge clk);
    if (mismatches == 0 && points_due.size() == 0) begin
      $display("sphere_halton_point verification clean");
    end else begin
      $display("sphere_halton_point verification failed");
    end
    $finish;
  end

endmodule
